// ----- rtl/ese_pkg.sv -----
`timescale 1ns / 1ps

package ese_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 10;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_HI,
		RD_MID
	} ese_rd_sel_t;

	typedef struct packed {
		logic        append;
		logic        key_load;
		logic        rd_en;
		ese_rd_sel_t rd_sel;
		logic        init;
		logic        expand;
		logic        clamp;
		logic        mid_load;
		logic        go_right;
		logic        go_left;
		logic        pend_set;
		logic        pend_found;
		logic        pend_use_mid;
		logic        publish;
	} ese_cmd_t;

	typedef struct packed {
		logic empty;
		logic eq;
		logic lt;
		logic hi_in;
		logic lo_le_hi;
	} ese_sts_t;

endpackage

// ----- rtl/ese_ram.sv -----
`timescale 1ns / 1ps

module ese_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/ese_ctrl.sv -----
`timescale 1ns / 1ps

module ese_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	output logic              out_valid,
	input  logic              out_ready,
	input  ese_pkg::ese_sts_t sts,
	output ese_pkg::ese_cmd_t cmd
);

	import ese_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP0,
		S_PROBE,
		S_CMPP,
		S_BIN,
		S_CMPB,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_SEARCH) begin
						cmd.key_load = 1'b1;
						if (sts.empty) begin
							cmd.pend_set = 1'b1;
							state_d      = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ZERO;
							state_d    = S_CMP0;
						end
					end else begin
						cmd.append = 1'b1;
					end
				end
			end
			S_CMP0: begin
				if (sts.eq) begin
					cmd.pend_set   = 1'b1;
					cmd.pend_found = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_PROBE;
				end
			end
			S_PROBE: begin
				if (sts.hi_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HI;
					state_d    = S_CMPP;
				end else begin
					cmd.clamp = 1'b1;
					state_d   = S_BIN;
				end
			end
			S_CMPP: begin
				if (sts.lt) begin
					cmd.expand = 1'b1;
					state_d    = S_PROBE;
				end else begin
					state_d = S_BIN;
				end
			end
			S_BIN: begin
				if (sts.lo_le_hi) begin
					cmd.mid_load = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_MID;
					state_d      = S_CMPB;
				end else begin
					cmd.pend_set = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_CMPB: begin
				if (sts.eq) begin
					cmd.pend_set     = 1'b1;
					cmd.pend_found   = 1'b1;
					cmd.pend_use_mid = 1'b1;
					state_d          = S_DONE;
				end else if (sts.lt) begin
					cmd.go_right = 1'b1;
					state_d      = S_BIN;
				end else begin
					cmd.go_left = 1'b1;
					state_d     = S_BIN;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("Result published over a stalled word.");

	a_publish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> (out_valid_q && state_q == S_IDLE))
		else $error("Published result not presented.");

endmodule

// ----- rtl/ese_dp.sv -----
`timescale 1ns / 1ps

module ese_dp #(
	parameter int DEPTH = ese_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ese_pkg::ese_cmd_t                 cmd,
	output ese_pkg::ese_sts_t                 sts,
	input  logic signed [ese_pkg::DATA_W-1:0] value,
	input  logic                              first,
	output logic                              found,
	output logic [ese_pkg::POS_W-1:0]         position
);

	import ese_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = CW + 1;

	logic [CW-1:0]            count_q;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [AW-1:0]            rd_addr;
	logic [DATA_W-1:0]        rd_data;
	logic signed [DATA_W-1:0] key_q;
	logic [BW-1:0]            lo_q;
	logic [BW-1:0]            hi_q;
	logic [BW-1:0]            mid_q;
	logic [BW-1:0]            mid_c;
	logic [BW-1:0]            count_ext;
	logic                     pend_found_q;
	logic [POS_W-1:0]         pend_pos_q;
	logic                     found_q;
	logic [POS_W-1:0]         position_q;

	assign count_ext = BW'(count_q);
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		if (cmd.append) begin
			if (first) begin
				wr_en = 1'b1;
			end else if (count_q < CW'(DEPTH)) begin
				wr_en   = 1'b1;
				wr_addr = count_q[AW-1:0];
			end
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_HI:   rd_addr = hi_q[AW-1:0];
			RD_MID:  rd_addr = mid_c[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	ese_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign sts.empty    = (count_q == '0);
	assign sts.eq       = ($signed(rd_data) == key_q);
	assign sts.lt       = ($signed(rd_data) < key_q);
	assign sts.hi_in    = (hi_q < count_ext);
	assign sts.lo_le_hi = (lo_q <= hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append) begin
			if (first) begin
				count_q <= CW'(1);
			end else if (count_q < CW'(DEPTH)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= value;
		end
		if (cmd.init) begin
			lo_q <= BW'(1);
			hi_q <= BW'(2);
		end else if (cmd.expand) begin
			lo_q <= hi_q;
			hi_q <= hi_q << 1;
		end else if (cmd.clamp) begin
			hi_q <= count_ext - BW'(1);
		end else if (cmd.go_right) begin
			lo_q <= mid_q + BW'(1);
		end else if (cmd.go_left) begin
			hi_q <= mid_q - BW'(1);
		end
		if (cmd.mid_load) begin
			mid_q <= mid_c;
		end
		if (cmd.pend_set) begin
			pend_found_q <= cmd.pend_found;
			pend_pos_q   <= cmd.pend_use_mid ? POS_W'(mid_q) : '0;
		end
		if (cmd.publish) begin
			found_q    <= pend_found_q;
			position_q <= pend_pos_q;
		end
	end

	assign found    = found_q;
	assign position = position_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Element count beyond capacity.");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_sel == RD_HI) |-> (hi_q < count_ext))
		else $error("Bound probe outside the loaded array.");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mid_load |-> (mid_c < count_ext && mid_c >= lo_q && mid_c <= hi_q))
		else $error("Midpoint outside the search range.");

	a_clamp_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clamp |=> (hi_q == count_ext - BW'(1)))
		else $error("Bound not clamped to the last element.");

endmodule

// ----- rtl/exponential_search_engine_core.sv -----
// Exponential search engine.
// Input channel (in_valid, in_ready): each word carries op, value and first.
// With op clear the word appends value to the stored array; first set empties
// the array beforehand, and appends to a full array are dropped. An append
// gives no result.
// With op set the word searches for value and gives exactly one result word
// on the output channel (out_valid, out_ready): found, and position, which
// is zero when the key is absent.
// A search reads one element per memory access through the single read port
// of the element memory. It gives a miss on an empty array and stops on
// a hit at element 0; otherwise it doubles the upper bound until the
// element there is not below the key or the bound passes the end of the
// array, and then runs a binary search between the bounds.
// A new word is taken only when no search is in progress, but it is taken
// while an earlier result still waits in the output register. A search that
// finishes while that result is stalled holds until out_ready is seen.
// Reset empties the array and drops any pending result; no clearing pass is
// needed and the block accepts words as soon as reset is released.

`timescale 1ns / 1ps

module exponential_search_engine_core #(
	parameter int DEPTH = ese_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic signed [ese_pkg::DATA_W-1:0] value,
	input  logic                              first,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [ese_pkg::POS_W-1:0]         position
);

	import ese_pkg::*;

	ese_cmd_t cmd;
	ese_sts_t sts;

	ese_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ese_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.value    (value),
		.first    (first),
		.found    (found),
		.position (position)
	);

endmodule
